>>> design/lzwd_pkg.sv
`default_nettype none

package lzwd_pkg;

    localparam int CODE_W            = 16;
    localparam int BYTE_W            = 8;
    localparam int CFG_W             = 32;
    localparam int WIDTH_W           = 5;
    localparam int PEND_W            = 17;
    localparam int NFC_W             = 32;
    localparam int MAX_CODE_BITS_DEF = 16;
    localparam int MIN_CODE_BITS     = 12;

    localparam logic [CODE_W-1:0]  CODE_END        = 16'd257;
    localparam logic [NFC_W-1:0]   CODE_FIRST_FREE = 32'd258;
    localparam logic [WIDTH_W-1:0] START_WIDTH     = 5'd9;
    localparam logic [WIDTH_W-1:0] RESET_MAX_BITS  = 5'd12;
    localparam logic [CFG_W-1:0]   RESET_COUNT_DEF = 32'hFFFF_FFFF;

    typedef enum logic {
        CMD_DECODE = 1'b0,
        CMD_DRAIN  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CODE_W-1:0] code;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_ENDED   = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic {
        REG_MAX_CODE_BITS = 1'b0,
        REG_RESET_COUNT   = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_WALK_RD,
        S_WALK_WAIT,
        S_FIN,
        S_FIX0
    } back_state_t;

endpackage

`default_nettype wire

>>> design/lzwd_ram.sv
`default_nettype none

module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/lzwd_front.sv
`default_nettype none

module lzwd_front
    import lzwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [CODE_W-1:0] code,
    output logic              q_valid,
    output cmd_t              q_cmd,
    input  logic              q_pop
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    cmd_t       cmd_in;

    assign in_stall = (count_reg == 2'd2);
    assign accept   = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.kind = op ? CMD_DRAIN : CMD_DECODE;
        cmd_in.code = code;
    end

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        unique case ({accept, q_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_fill_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !q_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count lost a transaction");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

endmodule

`default_nettype wire

>>> design/lzwd_back.sv
`default_nettype none

module lzwd_back
    import lzwd_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    input  logic [WIDTH_W-1:0] eff_max_bits,
    input  logic [CFG_W-1:0]   reset_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [BYTE_W-1:0]  data_byte,
    output logic               byte_valid,
    output logic               last_of_string,
    output logic [PEND_W-1:0]  pending_bytes,
    output logic [WIDTH_W-1:0] next_code_width,
    output logic [1:0]         status
);

    localparam int AW    = MAX_CODE_BITS;
    localparam int DEPTH = 1 << AW;
    localparam logic [AW:0] STEP_LIMIT = (AW+1)'(DEPTH - 1);

    back_state_t        state_reg, state_next;
    logic [AW:0]        pending_reg, pending_next;
    logic [CODE_W-1:0]  prev_reg, prev_next;
    logic [NFC_W-1:0]   nfc_reg, nfc_next;
    logic [WIDTH_W-1:0] width_reg, width_next;
    logic               awaiting_reg, awaiting_next;
    logic               ended_reg, ended_next;
    logic [CODE_W-1:0]  cur_reg, cur_next;
    logic [AW:0]        n_reg, n_next;
    logic               undef_reg, undef_next;
    logic [CODE_W-1:0]  code_reg, code_next;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic               byte_valid_reg;
    logic               last_reg;
    logic [PEND_W-1:0]  pend_out_reg;
    logic [WIDTH_W-1:0] width_out_reg;
    status_t            status_reg;

    logic               load;
    logic [BYTE_W-1:0]  ld_byte;
    logic               ld_valid;
    logic               ld_last;
    status_t            ld_status;

    logic [CODE_W-1:0]  code_mask, masked;
    logic               is_undef, out_free;
    logic [AW:0]        step_limit;
    logic [NFC_W-1:0]   table_cap, nfc_plus;

    logic               stack_we;
    logic [AW-1:0]      stack_waddr, stack_raddr;
    logic [BYTE_W-1:0]  stack_wdata, stack_rdata;
    logic               dict_we;
    logic [AW-1:0]      dict_waddr, dict_raddr;
    logic [CODE_W-1:0]  prefix_wdata, prefix_rdata;
    logic [BYTE_W-1:0]  suffix_wdata, suffix_rdata;

    assign stack_raddr = AW'(pending_reg - (AW+1)'(1));
    assign dict_raddr  = AW'(cur_reg);
    assign dict_waddr  = AW'(nfc_reg);
    assign code_mask   = CODE_W'((32'd1 << width_reg) - 32'd1);
    assign masked      = q_cmd.code & code_mask;
    assign is_undef    = ({16'd0, masked} >= nfc_reg);
    assign out_free    = !out_valid_reg || !out_stall;
    assign step_limit  = STEP_LIMIT - (AW+1)'(undef_reg);
    assign table_cap   = 32'd1 << eff_max_bits;
    assign nfc_plus    = nfc_reg + 32'd1;

    lzwd_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_stack (
        .clk     (clk),
        .wr_en   (stack_we),
        .wr_addr (stack_waddr),
        .wr_data (stack_wdata),
        .rd_addr (stack_raddr),
        .rd_data (stack_rdata)
    );

    lzwd_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_prefix (
        .clk     (clk),
        .wr_en   (dict_we),
        .wr_addr (dict_waddr),
        .wr_data (prefix_wdata),
        .rd_addr (dict_raddr),
        .rd_data (prefix_rdata)
    );

    lzwd_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_suffix (
        .clk     (clk),
        .wr_en   (dict_we),
        .wr_addr (dict_waddr),
        .wr_data (suffix_wdata),
        .rd_addr (dict_raddr),
        .rd_data (suffix_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        pending_next  = pending_reg;
        prev_next     = prev_reg;
        nfc_next      = nfc_reg;
        width_next    = width_reg;
        awaiting_next = awaiting_reg;
        ended_next    = ended_reg;
        cur_next      = cur_reg;
        n_next        = n_reg;
        undef_next    = undef_reg;
        code_next     = code_reg;
        q_pop         = 1'b0;
        load          = 1'b0;
        ld_byte       = '0;
        ld_valid      = 1'b0;
        ld_last       = 1'b0;
        ld_status     = ST_OK;
        stack_we      = 1'b0;
        stack_waddr   = '0;
        stack_wdata   = '0;
        dict_we       = 1'b0;
        prefix_wdata  = prev_reg;
        suffix_wdata  = cur_reg[BYTE_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.kind == CMD_DRAIN)
                    begin
                        if (pending_reg == '0)
                        begin
                            load      = 1'b1;
                            ld_status = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                    else
                    begin
                        priority if (ended_reg)
                        begin
                            load      = 1'b1;
                            ld_status = ST_ENDED;
                        end
                        else if (pending_reg != '0)
                        begin
                            load      = 1'b1;
                            ld_status = ST_REFUSED;
                        end
                        else if (awaiting_reg)
                        begin
                            stack_we      = 1'b1;
                            stack_waddr   = '0;
                            stack_wdata   = masked[BYTE_W-1:0];
                            pending_next  = (AW+1)'(1);
                            prev_next     = masked;
                            awaiting_next = 1'b0;
                            load          = 1'b1;
                        end
                        else if (masked == CODE_END)
                        begin
                            ended_next = 1'b1;
                            load       = 1'b1;
                            ld_status  = ST_ENDED;
                        end
                        else
                        begin
                            undef_next = is_undef;
                            cur_next   = is_undef ? prev_reg : masked;
                            n_next     = (AW+1)'(is_undef);
                            code_next  = masked;
                            state_next = S_WALK_RD;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                pending_next = pending_reg - (AW+1)'(1);
                load         = 1'b1;
                ld_byte      = stack_rdata;
                ld_valid     = 1'b1;
                ld_last      = (pending_reg == (AW+1)'(1));
                state_next   = S_IDLE;
            end
            S_WALK_RD:
            begin
                if (cur_reg > CODE_END && n_reg < step_limit)
                begin
                    state_next = S_WALK_WAIT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_WALK_WAIT:
            begin
                stack_we    = 1'b1;
                stack_waddr = n_reg[AW-1:0];
                stack_wdata = suffix_rdata;
                n_next      = n_reg + (AW+1)'(1);
                cur_next    = prefix_rdata;
                state_next  = S_WALK_RD;
            end
            S_FIN:
            begin
                stack_we     = 1'b1;
                stack_waddr  = n_reg[AW-1:0];
                stack_wdata  = cur_reg[BYTE_W-1:0];
                pending_next = n_reg + (AW+1)'(1);
                if (nfc_reg < table_cap)
                begin
                    dict_we = 1'b1;
                    if (width_reg < eff_max_bits
                        && nfc_reg == (32'd1 << width_reg) - 32'd1)
                    begin
                        width_next = width_reg + 5'd1;
                    end
                end
                prev_next = code_reg;
                nfc_next  = nfc_plus;
                if (nfc_plus == reset_count)
                begin
                    width_next    = START_WIDTH;
                    nfc_next      = CODE_FIRST_FREE;
                    awaiting_next = 1'b1;
                end
                if (undef_reg)
                begin
                    state_next = S_FIX0;
                end
                else
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIX0:
            begin
                stack_we    = 1'b1;
                stack_waddr = '0;
                stack_wdata = cur_reg[BYTE_W-1:0];
                load        = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pending_reg   <= '0;
            prev_reg      <= '0;
            nfc_reg       <= CODE_FIRST_FREE;
            width_reg     <= START_WIDTH;
            awaiting_reg  <= 1'b1;
            ended_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            prev_reg      <= prev_next;
            nfc_reg       <= nfc_next;
            width_reg     <= width_next;
            awaiting_reg  <= awaiting_next;
            ended_reg     <= ended_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        n_reg     <= n_next;
        undef_reg <= undef_next;
        code_reg  <= code_next;
        if (load)
        begin
            byte_reg       <= ld_byte;
            byte_valid_reg <= ld_valid;
            last_reg       <= ld_last;
            pend_out_reg   <= PEND_W'(pending_next);
            width_out_reg  <= width_next;
            status_reg     <= ld_status;
        end
    end

    assign out_valid       = out_valid_reg;
    assign data_byte       = byte_reg;
    assign byte_valid      = byte_valid_reg;
    assign last_of_string  = last_reg;
    assign pending_bytes   = pend_out_reg;
    assign next_code_width = width_out_reg;
    assign status          = status_reg;

    a_busy_output_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result register occupied during a multi-cycle operation");

    a_drain_gives_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |=> (out_valid_reg && byte_valid_reg))
        else $error("drain did not produce a byte");

    a_end_reported: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ended_reg) |-> (out_valid_reg && status_reg == ST_ENDED))
        else $error("end of stream not reported");

endmodule

`default_nettype wire

>>> design/lzw_code_decoder.sv
// LZW code decoder with variable code width.
// Input channel (in_valid / in_stall): one transaction carries op and code.
//   op = 0 decodes code, op = 1 drains one decoded byte, first byte first.
//   Feed each code with the width last reported on next_code_width.
// Output channel (out_valid / out_stall): exactly one result per input
//   transaction, in order, carrying the byte, flags, pending count, next
//   code width and status.
// A two-entry queue sits behind the input, so up to two transactions are
//   taken while a result waits on a stalled output; the output register holds
//   its transaction until out_stall is low.
// Refused codes, literals, the end code and an empty drain load the result
//   register from the queue; a byte drain passes S_DRAIN; a decode walks the
//   table (a registered read of the prefix and suffix memories, then a push
//   onto the string stack, per step), then S_FIN, and S_FIX0 if undefined.
// Configuration (cfg_write / cfg_index / cfg_data) is written only while idle
//   by the user; the block itself does not enforce this.
// Reset (rst_n low, asynchronous) empties the queue, clears pending bytes,
//   restores width 9 and the first free code, and needs no clearing pass.
`default_nettype none

module lzw_code_decoder
    import lzwd_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic [CODE_W-1:0]  code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [BYTE_W-1:0]  data_byte,
    output logic               byte_valid,
    output logic               last_of_string,
    output logic [PEND_W-1:0]  pending_bytes,
    output logic [WIDTH_W-1:0] next_code_width,
    output logic [1:0]         status
);

    localparam logic [WIDTH_W-1:0] TOP_BITS = WIDTH_W'(MAX_CODE_BITS);
    localparam logic [WIDTH_W-1:0] LOW_BITS = WIDTH_W'(MIN_CODE_BITS);

    logic [WIDTH_W-1:0] max_bits_reg, max_bits_next;
    logic [CFG_W-1:0]   reset_count_reg, reset_count_next;
    logic [WIDTH_W-1:0] raw_bits;
    logic               q_valid, q_pop;
    cmd_t               q_cmd;

    assign raw_bits = cfg_data[WIDTH_W-1:0];

    always_comb
    begin
        max_bits_next    = max_bits_reg;
        reset_count_next = reset_count_reg;
        if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MAX_CODE_BITS:
                begin
                    priority if (raw_bits < LOW_BITS)
                    begin
                        max_bits_next = LOW_BITS;
                    end
                    else if (raw_bits > TOP_BITS)
                    begin
                        max_bits_next = TOP_BITS;
                    end
                    else
                    begin
                        max_bits_next = raw_bits;
                    end
                end
                REG_RESET_COUNT:
                begin
                    reset_count_next = cfg_data;
                end
                default:
                begin
                    max_bits_next = max_bits_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bits_reg    <= RESET_MAX_BITS;
            reset_count_reg <= RESET_COUNT_DEF;
        end
        else
        begin
            max_bits_reg    <= max_bits_next;
            reset_count_reg <= reset_count_next;
        end
    end

    lzwd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .code     (code),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    lzwd_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_pop           (q_pop),
        .eff_max_bits    (max_bits_reg),
        .reset_count     (reset_count_reg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .data_byte       (data_byte),
        .byte_valid      (byte_valid),
        .last_of_string  (last_of_string),
        .pending_bytes   (pending_bytes),
        .next_code_width (next_code_width),
        .status          (status)
    );

endmodule

`default_nettype wire
